// ===== rtl/heq_pkg.sv =====
// Shared constants and helpers for the histogram equalization block.
package heq_pkg;

  localparam int BINS       = 256;
  localparam int BIN_W      = $clog2(BINS);
  localparam int PIX_W      = 8;
  localparam int CNT_W      = 23;
  localparam int QUO_W      = 8;
  // 255 * count needs 8 more bits than the count itself
  localparam int NUM_W      = CNT_W + 8;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(4194304);
  localparam logic [BIN_W-1:0] LAST_BIN   = BIN_W'(BINS - 1);

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_MAP   = 1'b1;

  // Pixel values past the last bin fall into the last bin.
  function automatic logic [BIN_W-1:0] bin_of(input logic [PIX_W-1:0] pix);
    logic [PIX_W:0] wide;
    wide = {1'b0, pix};
    if (wide >= (PIX_W+1)'(BINS)) begin
      return LAST_BIN;
    end
    return BIN_W'(pix);
  endfunction

endpackage

// ===== rtl/heq_if.sv =====
// Request and result channel interfaces of the histogram equalization block.
interface heq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [heq_pkg::PIX_W-1:0] pixel;
  logic                     last;

  modport source (output valid, kind, pixel, last, input ready);
  modport sink   (input valid, kind, pixel, last, output ready);
endinterface

interface heq_out_if;
  logic                     valid;
  logic                     ready;
  logic [heq_pkg::PIX_W-1:0] mapped_pixel;

  modport source (output valid, mapped_pixel, input ready);
  modport sink   (input valid, mapped_pixel, output ready);
endinterface

// ===== rtl/heq_resq.sv =====
// Two-entry result queue with one table read in flight.
module heq_resq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      issue,
  input  logic [heq_pkg::PIX_W-1:0] rd_data,
  output logic                      slot_ok,
  heq_out_if.source                 out_if
);

  logic [heq_pkg::PIX_W-1:0] q_r [2];
  logic                      wp_r;
  logic                      rp_r;
  logic [1:0]                cnt_r;
  logic [1:0]                cnt_nxt;
  logic                      pend_r;
  logic                      push;
  logic                      pop;

  assign push = pend_r;
  assign pop  = out_if.valid && out_if.ready;

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.mapped_pixel = q_r[rp_r];

  // queued results plus the read in flight must not pass two
  assign slot_ok = ((cnt_r + {1'b0, pend_r}) < 2'd2) || pop;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
      cnt_r  <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= rd_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r + {1'b0, pend_r}) <= 2'd2)
    else $error("result queue overfilled");

  a_no_issue_full: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> slot_ok)
    else $error("map request issued without a free slot");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.mapped_pixel)))
    else $error("waiting result dropped or changed");

endmodule

// ===== rtl/histogram_equalization_top.sv =====
// Top level: histogram count, table build and pixel map of the equalizer.
//
// channel  dir  ports                          request / result
// in_if    in   valid ready kind pixel last    count or map request
// out_if   out  valid ready mapped_pixel       equalized pixel, map requests only
//
// Count and map requests are taken one per cycle while idle and a result slot is free;
// a count is a two-stage read-modify-write with forwarding on the synchronous bin memory.
// Sync active-low reset; intake then waits while every bin is cleared.
// A count request with last stops intake for a drain step and then, per bin,
// one read, one accumulate, eight division steps and one table write.
// Results queue two deep, the table read in flight counting as one of them.
module histogram_equalization_top (
  input  logic      clk,
  input  logic      rst_n,
  heq_in_if.sink    in_if,
  heq_out_if.source out_if
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DRAIN,
    ST_RD,
    ST_ACC,
    ST_DIV,
    ST_WR
  } state_t;

  state_t state_r;

  logic [heq_pkg::CNT_W-1:0]  hist_mem [heq_pkg::BINS];
  logic [heq_pkg::PIX_W-1:0]  tbl_mem  [heq_pkg::BINS];
  logic [heq_pkg::BINS-1:0]   tbl_vld_r;

  logic                       slot_ok;
  logic                       acc;
  logic                       cnt_acc;
  logic                       map_acc;
  logic [heq_pkg::BIN_W-1:0]  in_bin;

  logic                       s1_valid_r;
  logic [heq_pkg::BIN_W-1:0]  s1_bin_r;
  logic                       wb_valid_r;
  logic [heq_pkg::BIN_W-1:0]  wb_bin_r;
  logic [heq_pkg::CNT_W-1:0]  wb_data_r;
  logic [heq_pkg::CNT_W-1:0]  hist_rd_r;
  logic [heq_pkg::CNT_W-1:0]  inc_val;

  logic                       hist_re;
  logic [heq_pkg::BIN_W-1:0]  hist_raddr;
  logic                       hist_we;
  logic [heq_pkg::BIN_W-1:0]  hist_waddr;
  logic [heq_pkg::CNT_W-1:0]  hist_wdata;

  logic [heq_pkg::PIX_W-1:0]  tbl_rd_r;
  logic                       tbl_rdv_r;
  logic                       tbl_we;
  logic [heq_pkg::QUO_W-1:0]  tbl_wdata;

  logic [heq_pkg::CNT_W-1:0]  total_r;
  logic [heq_pkg::CNT_W-1:0]  cum_r;
  logic [heq_pkg::CNT_W-1:0]  cum_nxt;
  logic [heq_pkg::BIN_W-1:0]  idx_r;
  logic [heq_pkg::NUM_W-1:0]  rem_r;
  logic [heq_pkg::NUM_W-1:0]  dsh;
  logic [heq_pkg::QUO_W-1:0]  quo_r;
  logic [heq_pkg::STEP_W-1:0] step_r;

  assign in_if.ready = (state_r == ST_IDLE) && slot_ok;
  assign acc         = in_if.valid && in_if.ready;
  assign cnt_acc     = acc && (in_if.kind == heq_pkg::KIND_COUNT);
  assign map_acc     = acc && (in_if.kind == heq_pkg::KIND_MAP);
  assign in_bin      = heq_pkg::bin_of(in_if.pixel);

  // forward the write of the previous request to the same bin
  assign inc_val = ((wb_valid_r && (wb_bin_r == s1_bin_r)) ? wb_data_r : hist_rd_r)
                   + heq_pkg::CNT_W'(1);

  assign hist_re    = cnt_acc || (state_r == ST_RD);
  assign hist_raddr = (state_r == ST_RD) ? idx_r : in_bin;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = s1_bin_r;
    hist_wdata = inc_val;
    if (s1_valid_r) begin
      hist_we = 1'b1;
    end else if ((state_r == ST_ACC) || (state_r == ST_CLR)) begin
      hist_we    = 1'b1;
      hist_waddr = idx_r;
      hist_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_raddr];
    end
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
  end

  assign tbl_we    = (state_r == ST_WR);
  assign tbl_wdata = (total_r == '0) ? '0 : quo_r;

  always_ff @(posedge clk) begin
    if (map_acc) begin
      tbl_rd_r  <= tbl_mem[in_bin];
      tbl_rdv_r <= tbl_vld_r[in_bin];
    end
    if (tbl_we) begin
      tbl_mem[idx_r] <= tbl_wdata;
    end
  end

  heq_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (map_acc),
    .rd_data (tbl_rdv_r ? tbl_rd_r : '0),
    .slot_ok (slot_ok),
    .out_if  (out_if)
  );

  assign cum_nxt = cum_r + hist_rd_r;
  assign dsh     = heq_pkg::NUM_W'(total_r) << step_r;

  always_ff @(posedge clk) begin
    wb_bin_r  <= s1_bin_r;
    wb_data_r <= inc_val;
    if (cnt_acc) begin
      s1_bin_r <= in_bin;
    end
    unique case (state_r)
      ST_ACC: begin
        cum_r  <= cum_nxt;
        rem_r  <= (heq_pkg::NUM_W'(cum_nxt) << 8) - heq_pkg::NUM_W'(cum_nxt);
        quo_r  <= '0;
        step_r <= heq_pkg::STEP_W'(heq_pkg::QUO_W - 1);
      end
      ST_DIV: begin
        if (rem_r >= dsh) begin
          rem_r         <= rem_r - dsh;
          quo_r[step_r] <= 1'b1;
        end
        step_r <= step_r - heq_pkg::STEP_W'(1);
      end
      default: begin
      end
    endcase
    if (state_r == ST_DRAIN) begin
      cum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
      total_r    <= '0;
      idx_r      <= '0;
      tbl_vld_r  <= '0;
    end else begin
      wb_valid_r <= s1_valid_r;
      s1_valid_r <= cnt_acc && (total_r != heq_pkg::MAX_PIXELS);
      if (cnt_acc && (total_r != heq_pkg::MAX_PIXELS)) begin
        total_r <= total_r + heq_pkg::CNT_W'(1);
      end
      unique case (state_r)
        ST_CLR: begin
          idx_r <= idx_r + heq_pkg::BIN_W'(1);
          if (idx_r == heq_pkg::LAST_BIN) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cnt_acc && in_if.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          idx_r   <= '0;
          state_r <= ST_RD;
        end
        ST_RD: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          tbl_vld_r[idx_r] <= 1'b1;
          idx_r            <= idx_r + heq_pkg::BIN_W'(1);
          if (idx_r == heq_pkg::LAST_BIN) begin
            total_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_intake_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_if.ready)
    else $error("request taken during table build");

  a_update_not_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == ST_IDLE || state_r == ST_DRAIN))
    else $error("histogram update overlaps table build");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= heq_pkg::MAX_PIXELS)
    else $error("pixel total past saturation");

endmodule

// ===== tb/heq_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts equalized pixels from the request stream and compares the results.
module heq_checker (
  input  logic clk,
  input  logic rst_n,
  heq_in_if    in_mon,
  heq_out_if   out_mon,
  output int   error_count,
  output int   pending_results
);

  logic [heq_pkg::CNT_W-1:0] hist [heq_pkg::BINS];
  logic [heq_pkg::PIX_W-1:0] lut [heq_pkg::BINS];
  logic [heq_pkg::CNT_W-1:0] frame_pixels;
  logic [heq_pkg::PIX_W-1:0] mapped_q [$];

  // Turn the finished histogram into a new lookup table, then start a fresh frame.
  task automatic rebuild_lut();
    longint unsigned running;
    longint unsigned entry;
    int b;
    running = 0;
    for (b = 0; b < heq_pkg::BINS; b++) begin
      running += hist[b];
      entry = 0;
      if (frame_pixels != '0) begin
        entry = (255 * running) / frame_pixels;
        if (entry > 255) begin
          entry = 255;
        end
      end
      lut[b] = heq_pkg::PIX_W'(entry);
      hist[b] = '0;
    end
    frame_pixels = '0;
  endtask

  task automatic take_request(input logic kind, input logic [heq_pkg::PIX_W-1:0] pixel,
                              input logic last);
    int b;
    b = (int'(pixel) >= heq_pkg::BINS) ? heq_pkg::BINS - 1 : int'(pixel);
    if (kind == heq_pkg::KIND_MAP) begin
      // last is don't-care on a map request
      mapped_q.push_back(lut[b]);
    end else begin
      // once saturated the histogram is frozen, but last still triggers the build
      if (frame_pixels < heq_pkg::MAX_PIXELS) begin
        frame_pixels = frame_pixels + 1'b1;
        hist[b] = hist[b] + 1'b1;
      end
      if (last) begin
        rebuild_lut();
      end
    end
  endtask

  initial begin
    error_count = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin : watch
    logic [heq_pkg::PIX_W-1:0] want;
    int b;
    if (rst_n !== 1'b1) begin
      for (b = 0; b < heq_pkg::BINS; b++) begin
        hist[b] = '0;
        lut[b] = '0;
      end
      frame_pixels = '0;
      mapped_q.delete();
    end else begin
      // results first: a request taken at this edge cannot have produced one yet
      if (out_mon.valid && out_mon.ready) begin
        if (mapped_q.size() == 0) begin
          $error("unexpected result: mapped_pixel = %0d", out_mon.mapped_pixel);
          error_count++;
        end else begin
          want = mapped_q.pop_front();
          if (out_mon.mapped_pixel !== want) begin
            $error("mapped_pixel: expected %0d, got %0d", want, out_mon.mapped_pixel);
            error_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        take_request(in_mon.kind, in_mon.pixel, in_mon.last);
      end
    end
    pending_results = mapped_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, result backpressure and verdict.
module testbench;

  // a table build holds off intake, so the quiet limit must outlast it
  localparam int QUIET_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 3000;
  localparam int PHASE_REQUESTS = 275;
  localparam int IDLE_PCT [4]   = '{0, 75, 0, 25};
  localparam int STALL_PCT [4]  = '{0, 0, 75, 25};

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   stall_pct;
  int   requests_sent;
  int   quiet_cycles = 0;
  int   error_count;
  int   pending_results;

  heq_in_if  in_if ();
  heq_out_if out_if ();

  histogram_equalization_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  heq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_request(input logic kind, input logic [heq_pkg::PIX_W-1:0] pixel,
                              input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.pixel <= pixel;
    in_if.last  <= last;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    requests_sent++;
  endtask

  // one frame of count requests closed by last, with occasional map requests mixed in, then a burst of map requests
  task automatic send_frame();
    int frame_len;
    int map_len;
    int mode;
    int base;
    int i;
    logic [heq_pkg::PIX_W-1:0] pix;
    frame_len = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 65) : $urandom_range(64, 1);
    mode = $urandom_range(2, 0);
    base = $urandom_range(255, 0);
    for (i = 0; i < frame_len; i++) begin
      if ($urandom_range(19, 0) == 0) begin
        send_request(heq_pkg::KIND_MAP, heq_pkg::PIX_W'($urandom), 1'($urandom));
      end
      case (mode)
        0: pix = heq_pkg::PIX_W'($urandom);
        1: pix = heq_pkg::PIX_W'(base + $urandom_range(15, 0));
        default: pix = $urandom_range(1, 0) ? '1 : '0;
      endcase
      send_request(heq_pkg::KIND_COUNT, pix, i == frame_len - 1);
    end
    map_len = $urandom_range(40, 5);
    for (i = 0; i < map_len; i++) begin
      send_request(heq_pkg::KIND_MAP, heq_pkg::PIX_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) begin
      send_request(1'($urandom), heq_pkg::PIX_W'($urandom), $urandom_range(7, 0) == 0);
    end
  endtask

  initial begin
    int phase_end;
    in_if.valid   = 1'b0;
    in_if.kind    = heq_pkg::KIND_COUNT;
    in_if.pixel   = '0;
    in_if.last    = 1'b0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    requests_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // table still at reset: everything maps to zero, last on a map is ignored
    send_request(heq_pkg::KIND_MAP, 8'd0, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd255, 1'b1);
    send_request(heq_pkg::KIND_MAP, 8'd128, 1'b0);
    // single-pixel frame
    send_request(heq_pkg::KIND_COUNT, 8'd255, 1'b1);
    send_request(heq_pkg::KIND_MAP, 8'd0, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd254, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd255, 1'b0);
    // four-pixel frame with a map in the middle that still sees the old table
    send_request(heq_pkg::KIND_COUNT, 8'd0, 1'b0);
    send_request(heq_pkg::KIND_COUNT, 8'd255, 1'b0);
    send_request(heq_pkg::KIND_COUNT, 8'd128, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd128, 1'b1);
    send_request(heq_pkg::KIND_COUNT, 8'd128, 1'b1);
    send_request(heq_pkg::KIND_MAP, 8'd0, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd127, 1'b1);
    send_request(heq_pkg::KIND_MAP, 8'd128, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd129, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd255, 1'b0);
    send_request(heq_pkg::KIND_COUNT, 8'd200, 1'b1);
    send_request(heq_pkg::KIND_MAP, 8'd200, 1'b0);
    send_request(heq_pkg::KIND_MAP, 8'd199, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = IDLE_PCT[ph];
      stall_pct     = STALL_PCT[ph];
      phase_end     = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        if ($urandom_range(99, 0) < 80) begin
          send_frame();
        end else begin
          send_noise();
        end
      end
    end
    in_if.valid <= 1'b0;

    while (pending_results != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== histogram_equalization_top.f =====
rtl/heq_pkg.sv
rtl/heq_if.sv
rtl/heq_resq.sv
rtl/histogram_equalization_top.sv
tb/heq_checker.sv
tb/testbench.sv
